// ===== hdl/nfaec_pkg.sv =====
// Shared constants, word types and helpers for the epsilon-closure core.
`timescale 1ns / 1ps

package nfaec_pkg;

   localparam int NUM_STATES = 16;
   localparam int IDX_W      = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
   localparam int STATE_W    = 4;
   localparam int OUT_MASK_W = 16;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_QUERY  = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   typedef logic [NUM_STATES-1:0] mask_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic [STATE_W-1:0] from_state;
      logic [STATE_W-1:0] to_state;
      logic               is_epsilon;
   } req_word_type;

   typedef struct packed {
      logic [STATE_W-1:0]    queried_state;
      logic [OUT_MASK_W-1:0] closure_mask;
   } rsp_word_type;

   typedef struct packed {
      logic               insert;
      logic               clear;
      logic [STATE_W-1:0] from_state;
      logic [STATE_W-1:0] to_state;
   } row_wr_type;

   function automatic logic state_ok(input logic [STATE_W-1:0] s);
      return 32'(s) < NUM_STATES;
   endfunction

   function automatic logic [OUT_MASK_W-1:0] out_mask(input mask_type m);
      logic [OUT_MASK_W-1:0] r;
      r = '0;
      for (int i = 0; i < OUT_MASK_W && i < NUM_STATES; i++) begin
         r[i] = m[i];
      end
      return r;
   endfunction

endpackage

// ===== hdl/nfaec_cell.sv =====
// One cell of the closure chain: holds one adjacency row and expands the passing mask.
`timescale 1ns / 1ps

module nfaec_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  nfaec_pkg::row_wr_type            row_wr,
   input  logic [nfaec_pkg::IDX_W-1:0]      cell_index,
   input  nfaec_pkg::mask_type              mask_in,
   output nfaec_pkg::mask_type              mask_out
);

   nfaec_pkg::mask_type row_ff, row_in;
   nfaec_pkg::mask_type mask_ff, mask_in_nxt;

   always_comb begin
      row_in = row_ff;
      if (row_wr.clear) begin
         row_in = '0;
      end else if (row_wr.insert && (32'(row_wr.from_state) == 32'(cell_index))) begin
         row_in = row_ff | (nfaec_pkg::NUM_STATES'(1) << row_wr.to_state);
      end
   end

   always_comb begin
      mask_in_nxt = mask_in | (mask_in[cell_index] ? row_ff : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in_nxt;
   end

   assign mask_out = mask_ff;

endmodule

// ===== hdl/nfa_epsilon_closure_core.sv =====
// Top level of the epsilon-closure core: request control and the chain of row cells.
// Usage:
//   Request words arrive on req_valid / req_stall / req_word; a word is taken at a
//   rising edge with req_valid high and req_stall low. Operation insert stores an
//   epsilon edge, clear drops all edges, query returns one response word.
//   Responses leave on rsp_valid / rsp_stall / rsp_word and hold while stalled.
// Query passes:
//   Insert, clear and unused codes are handled while idle and start no pass. A query
//   sends the reached mask through the row of NUM_STATES cells, one cell per cycle.
//   Passes repeat until a pass adds no state: P passes, P at most the epsilon
//   distance to the farthest reachable state + 1, so at most NUM_STATES. rsp_valid
//   rises as the controller returns to idle; no new request is taken before that.
//   A query of a state outside the machine answers with an empty mask and no pass.
//   One request is worked on at a time; req_stall is high while a query runs.
// Reset:
//   Synchronous reset clears every adjacency row at once, drops the response valid
//   flag and returns the controller to idle.
// Stall:
//   A finished query waits in the controller while rsp_stall holds the previous
//   response word; new requests are taken only once it has moved out.
`timescale 1ns / 1ps

module nfa_epsilon_closure_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  nfaec_pkg::req_word_type req_word,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output nfaec_pkg::rsp_word_type rsp_word
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   state_type                          state_ff, state_in;
   logic [nfaec_pkg::IDX_W-1:0]        cnt_ff, cnt_in;
   nfaec_pkg::mask_type                ref_ff, ref_in;
   nfaec_pkg::mask_type                res_ff, res_in;
   logic [nfaec_pkg::STATE_W-1:0]      qstate_ff, qstate_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   nfaec_pkg::rsp_word_type            rsp_word_ff, rsp_word_in;

   logic                               req_accept;
   nfaec_pkg::row_wr_type              row_wr;
   nfaec_pkg::mask_type                head_mask;
   nfaec_pkg::mask_type                chain_mask [nfaec_pkg::NUM_STATES+1];
   nfaec_pkg::mask_type                start_mask;
   logic                               pass_end;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign start_mask = nfaec_pkg::NUM_STATES'(1) << req_word.from_state;
   assign pass_end   = (state_ff == ST_RUN) &&
                       (cnt_ff == nfaec_pkg::IDX_W'(nfaec_pkg::NUM_STATES - 1));

   always_comb begin
      row_wr.insert     = req_accept && (req_word.operation == nfaec_pkg::OP_INSERT) &&
                          req_word.is_epsilon &&
                          nfaec_pkg::state_ok(req_word.from_state) &&
                          nfaec_pkg::state_ok(req_word.to_state);
      row_wr.clear      = req_accept && (req_word.operation == nfaec_pkg::OP_CLEAR);
      row_wr.from_state = req_word.from_state;
      row_wr.to_state   = req_word.to_state;
   end

   assign head_mask     = (state_ff == ST_IDLE) ? start_mask
                                                : chain_mask[nfaec_pkg::NUM_STATES];
   assign chain_mask[0] = head_mask;

   for (genvar i = 0; i < nfaec_pkg::NUM_STATES; i++) begin : g_cell
      nfaec_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .row_wr     (row_wr),
         .cell_index (nfaec_pkg::IDX_W'(i)),
         .mask_in    (chain_mask[i]),
         .mask_out   (chain_mask[i+1])
      );
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ref_in       = ref_ff;
      res_in       = res_ff;
      qstate_in    = qstate_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_word.operation == nfaec_pkg::OP_QUERY)) begin
               qstate_in = req_word.from_state;
               cnt_in    = '0;
               if (nfaec_pkg::state_ok(req_word.from_state)) begin
                  ref_in   = start_mask;
                  state_in = ST_RUN;
               end else begin
                  res_in   = '0;
                  state_in = ST_DONE;
               end
            end
         end
         ST_RUN: begin
            cnt_in = cnt_ff + 1'b1;
            if (pass_end) begin
               cnt_in = '0;
               if (chain_mask[nfaec_pkg::NUM_STATES] == ref_ff) begin
                  res_in   = ref_ff;
                  state_in = ST_DONE;
               end else begin
                  ref_in = chain_mask[nfaec_pkg::NUM_STATES];
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_word_in.queried_state = qstate_ff;
               rsp_word_in.closure_mask  = nfaec_pkg::out_mask(res_ff);
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      ref_ff      <= ref_in;
      res_ff      <= res_in;
      qstate_ff   <= qstate_in;
      rsp_word_ff <= rsp_word_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_query_starts_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_word.operation == nfaec_pkg::OP_QUERY))
      |=> req_stall)
      else $error("query accepted but controller stayed idle");

   a_count_only_in_run: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) |-> (state_ff == ST_RUN))
      else $error("pass counter moving outside a query");

   a_closure_has_self: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && nfaec_pkg::state_ok(rsp_word.queried_state))
      |-> rsp_word.closure_mask[rsp_word.queried_state])
      else $error("closure lacks the queried state");

   a_bad_state_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !nfaec_pkg::state_ok(rsp_word.queried_state))
      |-> (rsp_word.closure_mask == '0))
      else $error("closure of an unknown state is not empty");

endmodule

// ===== tb/tb_nfa_epsilon_closure_core.sv =====
// Self-checking testbench for the epsilon-closure core: directed table, then random graphs.
`timescale 1ns / 1ps

module tb_nfa_epsilon_closure_core;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_WORDS   = 750;

   typedef struct packed {
      nfaec_pkg::req_word_type          word;
      logic                             fixed;
      logic [nfaec_pkg::OUT_MASK_W-1:0] mask;
   } plan_row_type;

   logic                    clock     = 1'b0;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   nfaec_pkg::req_word_type req_word  = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   nfaec_pkg::rsp_word_type rsp_word;

   nfaec_pkg::mask_type     eps_rows [nfaec_pkg::NUM_STATES];
   nfaec_pkg::rsp_word_type closure_expect_q [$];
   plan_row_type            plan_q [$];

   int errors          = 0;
   int words_sent      = 0;
   int counted_words   = 0;
   int queries_checked = 0;
   int chains_built    = 0;
   int idle_cycles     = 0;
   int hold_left       = 0;
   int wait_left       = 0;
   bit quick_mode      = 1'b0;
   bit hold_req        = 1'b0;

   nfa_epsilon_closure_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #2 clock = ~clock;

   function automatic nfaec_pkg::mask_type closure_of_state(
         input logic [nfaec_pkg::STATE_W-1:0] s);
      nfaec_pkg::mask_type reached;
      nfaec_pkg::mask_type grown;
      reached = '0;
      if (s >= nfaec_pkg::NUM_STATES) return reached;
      reached[s] = 1'b1;
      for (int r = 0; r < nfaec_pkg::NUM_STATES; r++) begin
         grown = reached;
         for (int i = 0; i < nfaec_pkg::NUM_STATES; i++) begin
            if (reached[i]) grown = grown | eps_rows[i];
         end
         if (grown == reached) break;
         reached = grown;
      end
      return reached;
   endfunction

   function automatic nfaec_pkg::req_word_type make_word(
         input logic [1:0] op,
         input logic [nfaec_pkg::STATE_W-1:0] from_s,
         input logic [nfaec_pkg::STATE_W-1:0] to_s,
         input logic eps);
      nfaec_pkg::req_word_type w;
      w.operation  = op;
      w.from_state = from_s;
      w.to_state   = to_s;
      w.is_epsilon = eps;
      return w;
   endfunction

   task automatic track_request(input nfaec_pkg::req_word_type w, input logic fixed,
                                input logic [nfaec_pkg::OUT_MASK_W-1:0] fmask);
      nfaec_pkg::rsp_word_type r;
      case (w.operation)
         nfaec_pkg::OP_INSERT: begin
            if (w.is_epsilon && w.from_state < nfaec_pkg::NUM_STATES &&
                w.to_state < nfaec_pkg::NUM_STATES)
               eps_rows[w.from_state][w.to_state] = 1'b1;
         end
         nfaec_pkg::OP_QUERY: begin
            r.queried_state = w.from_state;
            r.closure_mask  = fixed ? fmask : closure_of_state(w.from_state);
            closure_expect_q.push_back(r);
         end
         nfaec_pkg::OP_CLEAR: begin
            for (int i = 0; i < nfaec_pkg::NUM_STATES; i++) eps_rows[i] = '0;
         end
         default: ;
      endcase
      if (w.operation == nfaec_pkg::OP_QUERY || w.operation == nfaec_pkg::OP_CLEAR ||
          (w.operation == nfaec_pkg::OP_INSERT && w.is_epsilon))
         counted_words++;
   endtask

   task automatic send_word(input nfaec_pkg::req_word_type w, input logic fixed,
                            input logic [nfaec_pkg::OUT_MASK_W-1:0] fmask);
      int gap;
      gap = quick_mode ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      track_request(w, fixed, fmask);
      words_sent++;
   endtask

   task automatic plan(input logic [1:0] op, input logic [nfaec_pkg::STATE_W-1:0] from_s,
                       input logic [nfaec_pkg::STATE_W-1:0] to_s, input logic eps,
                       input logic fixed, input logic [nfaec_pkg::OUT_MASK_W-1:0] mask);
      plan_row_type row;
      row.word  = make_word(op, from_s, to_s, eps);
      row.fixed = fixed;
      row.mask  = mask;
      plan_q.push_back(row);
   endtask

   initial begin : rsp_side
      nfaec_pkg::rsp_word_type expected;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_stall <= 1'b0;
         end else begin
            if (rsp_valid && !rsp_stall) begin
               if (closure_expect_q.size() == 0) begin
                  $error("unexpected response word: queried_state %0d closure_mask %h",
                         rsp_word.queried_state, rsp_word.closure_mask);
                  errors++;
               end else begin
                  expected = closure_expect_q.pop_front();
                  queries_checked++;
                  if (rsp_word.queried_state !== expected.queried_state) begin
                     $error("queried_state: expected %0d, actual %0d",
                            expected.queried_state, rsp_word.queried_state);
                     errors++;
                  end
                  if (rsp_word.closure_mask !== expected.closure_mask) begin
                     $error("closure_mask: expected %h, actual %h",
                            expected.closure_mask, rsp_word.closure_mask);
                     errors++;
                  end
               end
               wait_left = quick_mode ? 0 : $urandom_range(0, 10);
            end
            if (hold_req) begin
               hold_left = HOLD_CYCLES;
               hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
               hold_left--;
               rsp_stall <= 1'b1;
            end else if (wait_left > 0) begin
               wait_left--;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
         $display("tb_nfa_epsilon_closure_core: FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      logic [nfaec_pkg::STATE_W-1:0] order [nfaec_pkg::NUM_STATES];
      logic [nfaec_pkg::STATE_W-1:0] swap;
      logic [nfaec_pkg::STATE_W-1:0] head;
      nfaec_pkg::req_word_type       w;
      int                            pick;
      int                            n_items;
      int                            shape;
      bit                            held;
      bit                            paused;

      held   = 1'b0;
      paused = 1'b0;
      for (int i = 0; i < nfaec_pkg::NUM_STATES; i++) eps_rows[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      plan(nfaec_pkg::OP_QUERY,  4'd0,  4'd0,  1'b0, 1'b1, 16'h0001);
      plan(nfaec_pkg::OP_QUERY,  4'd15, 4'd0,  1'b0, 1'b1, 16'h8000);
      plan(nfaec_pkg::OP_INSERT, 4'd0,  4'd15, 1'b0, 1'b0, '0);
      plan(nfaec_pkg::OP_QUERY,  4'd0,  4'd15, 1'b1, 1'b1, 16'h0001);
      plan(OP_UNUSED,            4'd0,  4'd15, 1'b1, 1'b0, '0);
      plan(nfaec_pkg::OP_QUERY,  4'd0,  4'd0,  1'b0, 1'b1, 16'h0001);
      plan(nfaec_pkg::OP_INSERT, 4'd15, 4'd15, 1'b1, 1'b0, '0);
      plan(nfaec_pkg::OP_QUERY,  4'd15, 4'd15, 1'b1, 1'b1, 16'h8000);
      plan(nfaec_pkg::OP_INSERT, 4'd0,  4'd1,  1'b1, 1'b0, '0);
      plan(nfaec_pkg::OP_INSERT, 4'd1,  4'd2,  1'b1, 1'b0, '0);
      plan(nfaec_pkg::OP_INSERT, 4'd2,  4'd0,  1'b1, 1'b0, '0);
      plan(nfaec_pkg::OP_QUERY,  4'd1,  4'd0,  1'b0, 1'b0, '0);
      plan(nfaec_pkg::OP_INSERT, 4'd2,  4'd15, 1'b1, 1'b0, '0);
      plan(nfaec_pkg::OP_QUERY,  4'd0,  4'd0,  1'b0, 1'b0, '0);
      plan(nfaec_pkg::OP_INSERT, 4'd15, 4'd14, 1'b1, 1'b0, '0);
      plan(nfaec_pkg::OP_QUERY,  4'd15, 4'd0,  1'b0, 1'b0, '0);
      plan(OP_UNUSED,            4'd15, 4'd15, 1'b1, 1'b0, '0);
      plan(nfaec_pkg::OP_QUERY,  4'd2,  4'd0,  1'b0, 1'b0, '0);
      plan(nfaec_pkg::OP_CLEAR,  4'd15, 4'd15, 1'b1, 1'b0, '0);
      plan(nfaec_pkg::OP_QUERY,  4'd0,  4'd0,  1'b0, 1'b1, 16'h0001);
      plan(nfaec_pkg::OP_QUERY,  4'd15, 4'd15, 1'b1, 1'b1, 16'h8000);
      plan(nfaec_pkg::OP_INSERT, 4'd15, 4'd0,  1'b1, 1'b0, '0);
      plan(nfaec_pkg::OP_QUERY,  4'd15, 4'd0,  1'b0, 1'b0, '0);
      plan(nfaec_pkg::OP_CLEAR,  4'd0,  4'd0,  1'b0, 1'b0, '0);

      foreach (plan_q[k]) send_word(plan_q[k].word, plan_q[k].fixed, plan_q[k].mask);

      while (words_sent < RANDOM_WORDS) begin
         quick_mode = ($urandom_range(0, 3) == 0);

         if (!held && words_sent > 250) begin
            held       = 1'b1;
            quick_mode = 1'b1;
            hold_req   = 1'b1;
            for (int k = 0; k < 6; k++)
               send_word(make_word(nfaec_pkg::OP_QUERY,
                                   nfaec_pkg::STATE_W'($urandom),
                                   nfaec_pkg::STATE_W'($urandom), 1'($urandom)),
                         1'b0, '0);
         end
         if (!paused && words_sent > 500) begin
            paused = 1'b1;
            req_valid <= 1'b0;
            while (closure_expect_q.size() != 0) @(posedge clock);
         end

         if ($urandom_range(0, 3) != 0)
            send_word(make_word(nfaec_pkg::OP_CLEAR, nfaec_pkg::STATE_W'($urandom),
                                nfaec_pkg::STATE_W'($urandom), 1'($urandom)),
                      1'b0, '0);

         shape = $urandom_range(0, 9);
         if (shape < 3) begin
            // thread every state into one long epsilon path
            for (int k = 0; k < nfaec_pkg::NUM_STATES; k++)
               order[k] = nfaec_pkg::STATE_W'(k);
            for (int k = nfaec_pkg::NUM_STATES - 1; k > 0; k--) begin
               pick     = $urandom_range(0, k);
               swap     = order[k];
               order[k] = order[pick];
               order[pick] = swap;
            end
            for (int k = 0; k < nfaec_pkg::NUM_STATES - 1; k++)
               send_word(make_word(nfaec_pkg::OP_INSERT, order[k], order[k + 1], 1'b1),
                         1'b0, '0);
            head = order[0];
            chains_built++;
         end else if (shape < 9) begin
            n_items = $urandom_range(1, 24);
            for (int k = 0; k < n_items; k++) begin
               w = make_word(nfaec_pkg::OP_INSERT, nfaec_pkg::STATE_W'($urandom),
                             nfaec_pkg::STATE_W'($urandom), $urandom_range(0, 7) != 0);
               if ($urandom_range(0, 15) == 0) w.operation = OP_UNUSED;
               send_word(w, 1'b0, '0);
            end
            head = nfaec_pkg::STATE_W'($urandom);
         end else begin
            n_items = $urandom_range(1, 8);
            for (int k = 0; k < n_items; k++)
               send_word(make_word(2'($urandom), nfaec_pkg::STATE_W'($urandom),
                                   nfaec_pkg::STATE_W'($urandom), 1'($urandom)),
                         1'b0, '0);
            head = nfaec_pkg::STATE_W'($urandom);
         end

         n_items = $urandom_range(1, 5);
         for (int k = 0; k < n_items; k++) begin
            w = make_word(nfaec_pkg::OP_QUERY, nfaec_pkg::STATE_W'($urandom),
                          nfaec_pkg::STATE_W'($urandom), 1'($urandom));
            if ($urandom_range(0, 1) == 0) w.from_state = head;
            send_word(w, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (closure_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d request words (%0d effective), %0d closures checked,",
               words_sent, counted_words, queries_checked);
      $display("  %0d full-length epsilon chains, one long response hold and one drain pause",
               chains_built);
      if (errors == 0)
         $display("tb_nfa_epsilon_closure_core: PASS");
      else
         $display("tb_nfa_epsilon_closure_core: FAIL");
      $finish;
   end

endmodule
